[rtl/utf8_check_column_count_unit_macros.svh]
// Assertion macros shared by the UTF-8 check and column count unit.
`ifndef UTF8_CHECK_COLUMN_COUNT_UNIT_MACROS_SVH
`define UTF8_CHECK_COLUMN_COUNT_UNIT_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define U8CC_ASSERT_SAME(label, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |-> (effect)) \
    else $error("u8cc: same-cycle check failed");

// Check a consequence in the cycle after its cause.
`define U8CC_ASSERT_NEXT(label, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error("u8cc: next-cycle check failed");

`endif

[rtl/u8cc_pkg.sv]
// Types, constants and helper functions for the UTF-8 check and column count unit.
package u8cc_pkg;

  localparam int unsigned COUNT_W = 16;
  localparam int unsigned BYTE_W  = 8;

  // Requested count ceiling; the counters never go beyond 16 bits.
  localparam longint unsigned MAX_COUNT = 64'd65535;
  localparam logic [COUNT_W-1:0] COUNT_CAP =
    (MAX_COUNT > 64'hFFFF) ? {COUNT_W{1'b1}} : COUNT_W'(MAX_COUNT);

  // Byte boundaries of the accepted lead-byte ranges.
  localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_LO    = 8'hC2;
  localparam logic [BYTE_W-1:0] LEAD2_HI    = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD3_LO    = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_HI    = 8'hEF;
  localparam logic [BYTE_W-1:0] LEAD4_LO    = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_HI    = 8'hF4;
  localparam logic [BYTE_W-1:0] CONT_MASK   = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG    = 8'h80;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_BAD
  } byte_class_t;

  typedef struct packed {
    logic [COUNT_W-1:0] column_count;
    logic               utf8_ok;
  } result_t;

  // Sort a byte seen outside a multi-byte character.
  function automatic byte_class_t classify(input logic [BYTE_W-1:0] value);
    byte_class_t cls;
    if (value < ASCII_LIMIT) begin
      cls = CLS_ASCII;
    end else if (value >= LEAD2_LO && value <= LEAD2_HI) begin
      cls = CLS_LEAD2;
    end else if (value >= LEAD3_LO && value <= LEAD3_HI) begin
      cls = CLS_LEAD3;
    end else if (value >= LEAD4_LO && value <= LEAD4_HI) begin
      cls = CLS_LEAD4;
    end else begin
      cls = CLS_BAD;
    end
    return cls;
  endfunction

  // Add a small amount and stop at the count ceiling.
  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] value,
                                                 input logic [1:0] amount);
    logic [COUNT_W:0] sum;
    sum = {1'b0, value} + {{(COUNT_W-1){1'b0}}, amount};
    if (sum >= {1'b0, COUNT_CAP}) begin
      return COUNT_CAP;
    end
    return sum[COUNT_W-1:0];
  endfunction

endpackage

[rtl/u8cc_in_if.sv]
// Byte request channel: one string byte and its end-of-string flag.
interface u8cc_in_if import u8cc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[rtl/u8cc_out_if.sv]
// Result request channel: column count and well-formed flag of one string.
interface u8cc_out_if import u8cc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] column_count;
  logic               utf8_ok;

  modport source (output valid, output column_count, output utf8_ok, input ready);
  modport sink   (input valid, input column_count, input utf8_ok, output ready);
endinterface

[rtl/utf8_check_column_count_unit.sv]
// Top level of the UTF-8 check and column count unit.
// Takes one string byte per cycle on the bytes channel and, on the byte flagged
// last_byte, returns one result on the result channel: utf8_ok tells whether the
// string was well formed (lead bytes 00-7F, C2-DF, E0-EF, F0-F4 with the matching
// number of 10xxxxxx bytes, nothing cut off), and column_count gives the display
// columns (ASCII 1, other characters 2) when the string is valid and
// localized_mode is set, else the byte count; both counts saturate at 65535.
// Every byte passes an input register and then one decode step into a result
// register, so a byte is accepted every cycle unless a last byte is held, and
// the result is registered from the last byte's decode; a last byte waits only
// while the sink has not taken a held result. The user writes localized_mode
// through cfg_write and cfg_data while no string is in progress (not enforced).
module utf8_check_column_count_unit import u8cc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  u8cc_in_if.sink    bytes,
  u8cc_out_if.source result
);

  `include "utf8_check_column_count_unit_macros.svh"

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_last;
  logic              s1_go;
  logic              out_room;
  logic              res_valid;
  result_t           res;

  // Hold a final byte only while the result register is occupied and not being taken
  assign s1_go       = s1_valid && (!s1_last || out_room);
  assign bytes.ready = !s1_valid || s1_go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.ready) begin
      s1_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      s1_byte <= bytes.data_byte;
      s1_last <= bytes.last_byte;
    end
  end

  u8cc_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .step      (s1_go),
    .step_byte (s1_byte),
    .step_last (s1_last),
    .res_valid (res_valid),
    .res       (res)
  );

  u8cc_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .load_res (res),
    .room     (out_room),
    .result   (result)
  );

  `U8CC_ASSERT_NEXT(a_final_byte_yields_result, s1_go && s1_last, result.valid)
  `U8CC_ASSERT_SAME(a_no_result_overwrite, result.valid && !result.ready, !res_valid)
  `U8CC_ASSERT_NEXT(a_request_enters_stage, bytes.valid && bytes.ready, s1_valid)

endmodule

[rtl/u8cc_scan.sv]
// Per-string scan state: decodes one byte per cycle while step is high and forms the result on the last byte.
module u8cc_scan import u8cc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_data,
  input  logic              step,
  input  logic [BYTE_W-1:0] step_byte,
  input  logic              step_last,
  output logic              res_valid,
  output result_t           res
);

  logic               mode;
  logic [1:0]         pend;
  logic               err;
  logic [COUNT_W-1:0] cols;
  logic [COUNT_W-1:0] total;

  logic [1:0]         pend_next;
  logic               err_next;
  logic [COUNT_W-1:0] cols_next;
  logic [COUNT_W-1:0] total_next;
  logic               is_cont;
  logic               ok;
  byte_class_t        cls;

  // Decode the byte against the current character state
  always_comb begin
    cls        = classify(step_byte);
    is_cont    = (step_byte & CONT_MASK) == CONT_TAG;
    pend_next  = pend;
    err_next   = err;
    cols_next  = cols;
    total_next = sat_add(total, 2'd1);
    if (pend != 2'd0) begin
      if (!is_cont) begin
        err_next  = 1'b1;
        pend_next = 2'd0;
      end else begin
        pend_next = pend - 2'd1;
      end
    end else begin
      unique case (cls)
        CLS_ASCII: begin
          cols_next = sat_add(cols, 2'd1);
        end
        CLS_LEAD2: begin
          pend_next = 2'd1;
          cols_next = sat_add(cols, 2'd2);
        end
        CLS_LEAD3: begin
          pend_next = 2'd2;
          cols_next = sat_add(cols, 2'd2);
        end
        CLS_LEAD4: begin
          pend_next = 2'd3;
          cols_next = sat_add(cols, 2'd2);
        end
        CLS_BAD: begin
          err_next = 1'b1;
        end
        default: begin
          err_next = 1'b1;
        end
      endcase
    end
  end

  // Build the result; a cut-off character makes the string invalid
  always_comb begin
    ok               = !err_next && (pend_next == 2'd0);
    res.utf8_ok      = ok;
    res.column_count = (ok && mode) ? cols_next : total_next;
    res_valid        = step && step_last;
  end

  // Advance the scan state, clear it after each final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= 1'b0;
      pend  <= 2'd0;
      err   <= 1'b0;
      cols  <= '0;
      total <= '0;
    end else begin
      if (cfg_write) begin
        mode <= cfg_data;
      end
      if (step) begin
        if (step_last) begin
          pend  <= 2'd0;
          err   <= 1'b0;
          cols  <= '0;
          total <= '0;
        end else begin
          pend  <= pend_next;
          err   <= err_next;
          cols  <= cols_next;
          total <= total_next;
        end
      end
    end
  end

endmodule

[rtl/u8cc_out_reg.sv]
// Result register: holds one finished result until the sink takes it.
module u8cc_out_reg import u8cc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     load_res,
  output logic        room,
  u8cc_out_if.source  result
);

  logic    valid;
  result_t hold;

  // Free when empty or when the held result leaves this cycle
  assign room = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  // Capture the payload on load
  always_ff @(posedge clk) begin
    if (load) begin
      hold <= load_res;
    end
  end

  assign result.valid        = valid;
  assign result.column_count = hold.column_count;
  assign result.utf8_ok      = hold.utf8_ok;

endmodule

[sim/tb_utf8_check_column_count_unit.sv]
// Self-checking testbench for the UTF-8 check and column count unit.
module tb_utf8_check_column_count_unit;
  import u8cc_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_BYTES = 1700;
  localparam int MAX_MISMATCH_PRINTS = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_data = 1'b0;

  u8cc_in_if  bytes_if ();
  u8cc_out_if result_if ();

  utf8_check_column_count_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .bytes     (bytes_if),
    .result    (result_if)
  );

  always #CLK_HALF clk = ~clk;

  // Shadow copy of the string scanner and its mode register
  logic [1:0]         cont_left = 2'd0;
  logic               bad_seen = 1'b0;
  logic [COUNT_W-1:0] col_sum = '0;
  logic [COUNT_W-1:0] byte_sum = '0;
  logic               mode_on = 1'b0;
  result_t            expected_counts[$];

  logic [BYTE_W-1:0]  text_buf[$];
  bit                 idle_on = 1'b1;
  int                 mismatches = 0;
  int                 strings_checked = 0;
  int                 bytes_accepted = 0;
  int                 stall_left = 0;

  initial begin
    bytes_if.valid = 1'b0;
    bytes_if.data_byte = 8'h41;
    bytes_if.last_byte = 1'b0;
    result_if.ready = 1'b0;
  end

  // Add to a running count and stop at the ceiling
  function automatic logic [COUNT_W-1:0] add_capped(input logic [COUNT_W-1:0] value,
                                                    input int unsigned amount);
    int unsigned sum;
    sum = value + amount;
    if (sum >= COUNT_CAP) return COUNT_CAP;
    return COUNT_W'(sum);
  endfunction

  // Advance the shadow scanner by one byte; queue the string result on the last byte
  task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic last);
    result_t res;
    byte_sum = add_capped(byte_sum, 1);
    if (cont_left != 2'd0) begin
      if ((b & CONT_MASK) != CONT_TAG) begin
        bad_seen = 1'b1;
        cont_left = 2'd0;
      end else begin
        cont_left = cont_left - 2'd1;
      end
    end else if (b < ASCII_LIMIT) begin
      col_sum = add_capped(col_sum, 1);
    end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
      cont_left = 2'd1;
      col_sum = add_capped(col_sum, 2);
    end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
      cont_left = 2'd2;
      col_sum = add_capped(col_sum, 2);
    end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
      cont_left = 2'd3;
      col_sum = add_capped(col_sum, 2);
    end else begin
      bad_seen = 1'b1;
    end
    if (last) begin
      if (cont_left != 2'd0) bad_seen = 1'b1;
      res.utf8_ok = !bad_seen;
      res.column_count = (!bad_seen && mode_on) ? col_sum : byte_sum;
      expected_counts.push_back(res);
      cont_left = 2'd0;
      bad_seen = 1'b0;
      col_sum = '0;
      byte_sum = '0;
    end
  endtask

  task automatic flag_mismatch(input string what, input int unsigned want_v,
                               input int unsigned got_v);
    mismatches++;
    if (mismatches <= MAX_MISMATCH_PRINTS)
      $display("mismatch in %s: expected %0d, got %0d", what, want_v, got_v);
  endtask

  // Check each result request against the oldest expectation, then track byte requests
  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst) begin
      if (result_if.valid && result_if.ready) begin
        strings_checked++;
        if (expected_counts.size() == 0) begin
          flag_mismatch("unexpected result column_count", 0, result_if.column_count);
        end else begin
          want = expected_counts.pop_front();
          if (want.column_count !== result_if.column_count)
            flag_mismatch("column_count", want.column_count, result_if.column_count);
          if (want.utf8_ok !== result_if.utf8_ok)
            flag_mismatch("utf8_ok", want.utf8_ok, result_if.utf8_ok);
        end
      end
      if (bytes_if.valid && bytes_if.ready) begin
        bytes_accepted++;
        scan_byte(bytes_if.data_byte, bytes_if.last_byte);
      end
    end
  end

  // Hold off result requests in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      result_if.ready = 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      result_if.ready = 1'b0;
      stall_left = $urandom_range(0, 8);
    end else begin
      result_if.ready = 1'b1;
    end
  end

  // Drive one byte request, with an optional gap first, and wait for its acceptance
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      bytes_if.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    bytes_if.valid = 1'b1;
    bytes_if.data_byte = b;
    bytes_if.last_byte = last;
    do @(posedge clk); while (!bytes_if.ready);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++)
      send_byte(text_buf[i], i == text_buf.size() - 1);
  endtask

  // Drop the byte request and wait for all outstanding results plus the pipeline
  task automatic wait_drained();
    @(negedge clk);
    bytes_if.valid = 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_data = value;
    @(posedge clk);
    mode_on = value;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Byte counts with the mode register at its reset value
  task automatic test_reset_mode();
    text_buf = '{8'h01};
    send_text();
    text_buf = '{8'hFF};
    send_text();
    text_buf = '{8'hE0, 8'h80, 8'h80};
    send_text();
    wait_drained();
  endtask

  // Column counts at the top of every lead-byte range and at C2
  task automatic test_lead_ranges();
    write_mode(1'b1);
    text_buf = '{8'h7F};
    send_text();
    text_buf = '{8'hC2, 8'h80};
    send_text();
    text_buf = '{8'hDF, 8'hBF};
    send_text();
    text_buf = '{8'hEF, 8'hBF, 8'hBF};
    send_text();
    text_buf = '{8'hF4, 8'hBF, 8'hBF, 8'hBF};
    send_text();
  endtask

  // Truncation, bad continuation, a stray continuation byte and bad lead bytes
  task automatic test_malformed();
    text_buf = '{8'hEF, 8'h80};
    send_text();
    text_buf = '{8'hC2, 8'h41};
    send_text();
    text_buf = '{8'h80};
    send_text();
    text_buf = '{8'hC1};
    send_text();
    text_buf = '{8'hF5};
    send_text();
    wait_drained();
  endtask

  // Build a mostly well-formed string with random content, sometimes broken
  task automatic make_random_string();
    int chars;
    int kind;
    int width;
    chars = $urandom_range(1, 12);
    kind = $urandom_range(0, 99);
    text_buf.delete();
    if (kind < 5) begin
      for (int c = 0; c < chars; c++) text_buf.push_back(8'($urandom_range(1, 255)));
      return;
    end
    for (int c = 0; c < chars; c++) begin
      width = $urandom_range(1, 4);
      case (width)
        1: text_buf.push_back(8'($urandom_range(1, 127)));
        2: text_buf.push_back(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
        3: text_buf.push_back(8'($urandom_range(LEAD3_LO, LEAD3_HI)));
        default: text_buf.push_back(8'($urandom_range(LEAD4_LO, LEAD4_HI)));
      endcase
      for (int k = 1; k < width; k++) text_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
    end
    if (kind < 15) begin
      text_buf.insert($urandom_range(0, text_buf.size()), 8'($urandom_range(1, 255)));
    end else if (kind < 23 && text_buf.size() > 1) begin
      void'(text_buf.pop_back());
    end
  endtask

  // Random strings in four phases, alternating the mode, the last with no idling
  task automatic test_random_strings();
    int phase_bytes;
    for (int phase = 0; phase < 4; phase++) begin
      write_mode(phase[0]);
      idle_on = (phase != 3);
      phase_bytes = 0;
      while (phase_bytes < RANDOM_BYTES / 4) begin
        make_random_string();
        phase_bytes += text_buf.size();
        send_text();
      end
      wait_drained();
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;
    test_reset_mode();
    test_lead_ranges();
    test_malformed();
    test_random_strings();
    wait_drained();
    $display("Covered %0d strings (%0d bytes): all lead ranges, malformed input,", strings_checked,
             bytes_accepted);
    $display("truncated and broken strings in both modes, with and without idling.");
    if (mismatches == 0 && expected_counts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, expected_counts.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // End the run if it hangs
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/u8cc_pkg.sv
rtl/u8cc_in_if.sv
rtl/u8cc_out_if.sv
rtl/u8cc_scan.sv
rtl/u8cc_out_reg.sv
rtl/utf8_check_column_count_unit.sv
sim/tb_utf8_check_column_count_unit.sv
